[rtl/segloc_pkg.sv]
// shared types and constants for the segment locator
package segloc_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int SIZE_BITS    = 32;

    localparam int OP_W  = 2;
    localparam int END_W = 40;
    localparam int SEG_W = 9;
    localparam int OFF_W = 32;

    // slot index into the cell row and a count that can reach the capacity itself
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int NUM_W = $clog2(MAX_SEGMENTS + 1);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [END_W-1:0] END_MAX = {END_W{1'b1}};

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [END_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [SEG_W-1:0] segment_number;
        logic [OFF_W-1:0] offset;
        logic             out_of_range;
    } rsp_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_slot;
        logic [END_W-1:0] wr_end;
        logic [END_W-1:0] pos;
    } ctl_t;

    // search result handed from cell to cell
    typedef struct packed {
        logic             found;
        logic [NUM_W-1:0] seg;
        logic [OFF_W-1:0] off;
    } hit_t;

endpackage

[rtl/segloc_cell.sv]
// one cell of the prefix-sum row: holds one cumulative end and forwards the search result
module segloc_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [segloc_pkg::IDX_W-1:0]   slot,
    input  segloc_pkg::ctl_t               ctl,
    input  logic [segloc_pkg::END_W-1:0]   prev_end,
    input  segloc_pkg::hit_t               hit_in,
    output logic [segloc_pkg::END_W-1:0]   end_out,
    output segloc_pkg::hit_t               hit_out
);
    import segloc_pkg::*;

    logic [END_W-1:0] end_reg;
    hit_t             hit_reg;
    hit_t             hit_next;
    logic [END_W-1:0] diff;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && ctl.wr_slot == slot)
        begin
            end_reg <= ctl.wr_end;
        end
    end

    assign diff = ctl.pos - prev_end;

    // an earlier cell's hit wins, so the first end reaching the position is the answer
    always_comb
    begin
        hit_next = '0;
        if (hit_in.found)
        begin
            hit_next = hit_in;
        end
        else if (end_reg >= ctl.pos)
        begin
            hit_next.found = 1'b1;
            hit_next.seg   = NUM_W'(slot) + NUM_W'(1);
            hit_next.off   = diff[OFF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign end_out = end_reg;
    assign hit_out = hit_reg;

endmodule

[rtl/segment_locator_prefix_search_top.sv]
// top level of the segment locator: command decode, row of prefix-sum cells, result register
//
// usage:
//   req channel (req_valid, req_stall, req_data) takes one command per transfer:
//   clear empties the table, append adds a segment size (low 32 bits, running
//   total saturates at 2^40-1, ignored when the 256 slots are full), query asks
//   for a position counted from 1. unused opcode 3 is dropped.
//   rsp channel (rsp_valid, rsp_stall, rsp_data) returns one transfer per query
//   only: segment number and offset counted from 1, or the out-of-range flag.
//   an out-of-range query does not walk the row. an in-range query walks the
//   result through the 256-cell row, one cell per clock, and its answer is
//   taken from the last cell.
//   one command is handled at a time: req_stall stays high from a query's
//   transfer until its result has been taken. while rsp_stall is high the result
//   holds steady on rsp_data.
//   reset empties the table and drops any pending result; stored ends are not
//   cleared, only the entry count and the running total.
module segment_locator_prefix_search_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  segloc_pkg::req_t  req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output segloc_pkg::rsp_t  rsp_data
);
    import segloc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_OUT    = 2'd2;

    localparam logic [NUM_W-1:0] FULL_COUNT = NUM_W'(MAX_SEGMENTS);

    logic [1:0]       state_reg, state_next;
    logic [NUM_W-1:0] count_reg, count_next;
    logic [END_W-1:0] total_reg, total_next;
    logic [END_W-1:0] pos_reg, pos_next;
    logic [NUM_W-1:0] walk_reg, walk_next;
    rsp_t             rsp_reg, rsp_next;

    logic             accept;
    logic [END_W:0]   sum;
    logic [END_W-1:0] sum_sat;
    logic             out_range;
    ctl_t             ctl;

    logic [END_W-1:0] end_chain [MAX_SEGMENTS+1];
    hit_t             hit_chain [MAX_SEGMENTS+1];

    assign accept = req_valid && !req_stall;

    assign sum     = {1'b0, total_reg} + {1'b0, (END_W)'(req_data.value[SIZE_BITS-1:0])};
    assign sum_sat = sum[END_W] ? END_MAX : sum[END_W-1:0];

    assign out_range = (count_reg == '0) || (req_data.value == '0)
                       || (req_data.value > total_reg);

    always_comb
    begin
        ctl.wr_en   = accept && req_data.opcode == OP_APPEND && count_reg != FULL_COUNT;
        ctl.wr_slot = count_reg[IDX_W-1:0];
        ctl.wr_end  = sum_sat;
        ctl.pos     = pos_reg;
    end

    assign end_chain[0] = '0;
    assign hit_chain[0] = '0;

    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        segloc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot     (IDX_W'(i)),
            .ctl      (ctl),
            .prev_end (end_chain[i]),
            .hit_in   (hit_chain[i]),
            .end_out  (end_chain[i+1]),
            .hit_out  (hit_chain[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        total_next = total_reg;
        pos_next   = pos_reg;
        walk_next  = walk_reg;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_data.opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (ctl.wr_en)
                            begin
                                count_next = count_reg + NUM_W'(1);
                                total_next = sum_sat;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (out_range)
                            begin
                                rsp_next.segment_number = '0;
                                rsp_next.offset         = '0;
                                rsp_next.out_of_range   = 1'b1;
                                state_next              = ST_OUT;
                            end
                            else
                            begin
                                pos_next   = req_data.value;
                                walk_next  = '0;
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                // the last cell holds a settled result once every cell has seen the position
                if (walk_reg == FULL_COUNT)
                begin
                    rsp_next.segment_number = SEG_W'(hit_chain[MAX_SEGMENTS].seg);
                    rsp_next.offset         = hit_chain[MAX_SEGMENTS].off;
                    rsp_next.out_of_range   = 1'b0;
                    state_next              = ST_OUT;
                end
                else
                begin
                    walk_next = walk_reg + NUM_W'(1);
                end
            end
            ST_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            walk_reg  <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        rsp_reg <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = (state_reg == ST_OUT);
    assign rsp_data  = rsp_reg;

endmodule
